// ===== sv/srafp_pkg.sv =====
package srafp_pkg;

	localparam int unsigned ADDR_W  = 15;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned ACT_W   = 2;
	localparam int unsigned POS_W   = 3;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;

	localparam logic [POS_W-1:0] POS_SYNC1 = 3'd0;
	localparam logic [POS_W-1:0] POS_SYNC2 = 3'd1;
	localparam logic [POS_W-1:0] POS_ADDR_LO = 3'd2;
	localparam logic [POS_W-1:0] POS_ADDR_HI = 3'd3;
	localparam logic [POS_W-1:0] POS_CNT_LO = 3'd4;
	localparam logic [POS_W-1:0] POS_CNT_HI = 3'd5;
	localparam logic [POS_W-1:0] POS_BURST = 3'd6;

	localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ADDR_LOW  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ADDR_HIGH = 1'd1;

	localparam logic [ADDR_W-1:0] ADDR_LOW_RST  = 15'd0;
	localparam logic [ADDR_W-1:0] ADDR_HIGH_RST = 15'h7FFF;

	typedef struct packed {
		logic              byte_taken;
		logic [ACT_W-1:0]  action;
		logic [ADDR_W-1:0] reg_addr;
		logic [BYTE_W-1:0] write_data;
	} result_t;

endpackage

// ===== sv/srafp_parser.sv =====
module srafp_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        byte_valid,
	input  logic [srafp_pkg::BYTE_W-1:0] rx_byte,
	input  logic [srafp_pkg::ADDR_W-1:0] addr_low,
	input  logic [srafp_pkg::ADDR_W-1:0] addr_high,
	output srafp_pkg::result_t          res
);
	import srafp_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [WORD_W-1:0] addr_word_q;
	logic [WORD_W-1:0] count_q;

	logic [POS_W-1:0]  pos_cur;
	logic [POS_W-1:0]  pos_d;
	logic [WORD_W-1:0] addr_word_d;
	logic [WORD_W-1:0] count_d;
	logic [ADDR_W-1:0] addr;
	logic              burst_ok;

	assign pos_cur  = (pos_q > POS_BURST) ? POS_SYNC1 : pos_q;
	assign addr     = addr_word_q[ADDR_W-1:0];
	assign burst_ok = (addr >= addr_low) && (addr <= addr_high) && (count_q != '0);

	always_comb begin
		pos_d       = pos_cur;
		addr_word_d = addr_word_q;
		count_d     = count_q;
		res         = '0;
		if (pos_cur < POS_BURST) begin
			if (byte_valid) begin
				res.byte_taken = 1'b1;
				unique case (pos_cur)
					POS_SYNC1: pos_d = (rx_byte == SYNC_FIRST) ? POS_SYNC2 : POS_SYNC1;
					POS_SYNC2: pos_d = (rx_byte == SYNC_SECOND) ? POS_ADDR_LO : POS_SYNC1;
					POS_ADDR_LO: begin
						addr_word_d = {addr_word_q[WORD_W-1:BYTE_W], rx_byte};
						pos_d       = POS_ADDR_HI;
					end
					POS_ADDR_HI: begin
						addr_word_d = {rx_byte, addr_word_q[BYTE_W-1:0]};
						pos_d       = POS_CNT_LO;
					end
					POS_CNT_LO: begin
						count_d = {count_q[WORD_W-1:BYTE_W], rx_byte};
						pos_d   = POS_CNT_HI;
					end
					default: begin
						count_d = {rx_byte, count_q[BYTE_W-1:0]};
						pos_d   = POS_BURST;
					end
				endcase
			end
		end else if (!burst_ok) begin
			pos_d = POS_SYNC1;
		end else if (addr_word_q[WORD_W-1]) begin
			if (byte_valid) begin
				res.byte_taken = 1'b1;
				res.action     = ACT_WRITE;
				res.reg_addr   = addr;
				res.write_data = rx_byte;
				addr_word_d    = addr_word_q + WORD_W'(1);
				count_d        = count_q - WORD_W'(1);
			end
		end else begin
			res.action  = ACT_READ;
			res.reg_addr = addr;
			addr_word_d = addr_word_q + WORD_W'(1);
			count_d     = count_q - WORD_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_SYNC1;
		end else if (step) begin
			pos_q <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			addr_word_q <= addr_word_d;
			count_q     <= count_d;
		end
	end

`ifndef SYNTH
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_BURST)
		else $error("frame position beyond burst");

	a_write_takes: assert property (@(posedge clk) disable iff (!arst_n)
		res.action == ACT_WRITE |-> res.byte_taken && byte_valid)
		else $error("write without a taken byte");

	a_read_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		res.action == ACT_READ |-> !res.byte_taken && pos_q == POS_BURST)
		else $error("read request outside burst or with a taken byte");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && pos_q < POS_BURST && !byte_valid |=> $stable(pos_q))
		else $error("capture advanced without a byte");

	a_burst_exit: assert property (@(posedge clk) disable iff (!arst_n)
		step && pos_q == POS_BURST && !burst_ok |=> pos_q == POS_SYNC1)
		else $error("burst did not return to hunting");
`endif

endmodule

// ===== sv/serial_register_access_frame_parser.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | byte_valid, rx_byte
// out     | output    | out_valid / out_stall | byte_taken, action, reg_addr, write_data
// cfg     | input     | wr_en                 | wr_index, wr_data
//
// One item per cycle while out_stall is low; each item passes the input register, then the result register.
// Frame state advances as an item moves from the input register to the result register.
// Reset puts the parser in sync hunting and the address range to its full span.
// out_stall holds a valid result register; a full input register then holds and raises in_stall.
module serial_register_access_frame_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           byte_valid,
	input  logic [srafp_pkg::BYTE_W-1:0]    rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           byte_taken,
	output logic [srafp_pkg::ACT_W-1:0]     action,
	output logic [srafp_pkg::ADDR_W-1:0]    reg_addr,
	output logic [srafp_pkg::BYTE_W-1:0]    write_data,
	input  logic                           wr_en,
	input  logic [srafp_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [srafp_pkg::ADDR_W-1:0]    wr_data
);
	import srafp_pkg::*;

	logic              valid_s1;
	logic              byte_valid_s1;
	logic [BYTE_W-1:0] rx_byte_s1;
	logic              valid_s2;
	result_t           res_s2;
	result_t           res;
	logic [ADDR_W-1:0] addr_low_q;
	logic [ADDR_W-1:0] addr_high_q;
	logic              out_free;
	logic              advance;

	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_low_q  <= ADDR_LOW_RST;
			addr_high_q <= ADDR_HIGH_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_ADDR_LOW:  addr_low_q  <= wr_data;
				CFG_ADDR_HIGH: addr_high_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_valid_s1 <= byte_valid;
			rx_byte_s1    <= rx_byte;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	srafp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.byte_valid (byte_valid_s1),
		.rx_byte    (rx_byte_s1),
		.addr_low   (addr_low_q),
		.addr_high  (addr_high_q),
		.res        (res)
	);

	assign out_valid  = valid_s2;
	assign byte_taken = res_s2.byte_taken;
	assign action     = res_s2.action;
	assign reg_addr   = res_s2.reg_addr;
	assign write_data = res_s2.write_data;

endmodule

// ===== tb/serial_register_access_frame_parser_test.sv =====
`timescale 1ns / 100ps

module serial_register_access_frame_parser_test;
	import srafp_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               byte_valid = 1'b0;
	logic [BYTE_W-1:0]  rx_byte = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               byte_taken;
	logic [ACT_W-1:0]   action;
	logic [ADDR_W-1:0]  reg_addr;
	logic [BYTE_W-1:0]  write_data;
	logic               wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [ADDR_W-1:0]  wr_data = '0;

	serial_register_access_frame_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_valid(byte_valid),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.byte_taken(byte_taken),
		.action(action),
		.reg_addr(reg_addr),
		.write_data(write_data),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	logic [POS_W-1:0]  frame_pos = POS_SYNC1;
	logic [WORD_W-1:0] addr_word = '0;
	logic [WORD_W-1:0] count_left = '0;
	logic [ADDR_W-1:0] range_lo = ADDR_LOW_RST;
	logic [ADDR_W-1:0] range_hi = ADDR_HIGH_RST;

	result_t           poll_outcomes_due[$];
	result_t           due_outcome;
	logic [BYTE_W-1:0] byte_stream[$];
	int                mismatches = 0;
	int                hold_cycles = 0;
	bit                quiet = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end

	function automatic result_t parse_poll(input logic bv, input logic [BYTE_W-1:0] b);
		result_t           r;
		logic [ADDR_W-1:0] a;
		r = '0;
		if (frame_pos != POS_BURST) begin
			if (!bv)
				return r;
			case (frame_pos)
				POS_SYNC1: frame_pos = (b == SYNC_FIRST) ? POS_SYNC2 : POS_SYNC1;
				POS_SYNC2: frame_pos = (b == SYNC_SECOND) ? POS_ADDR_LO : POS_SYNC1;
				POS_ADDR_LO: begin
					addr_word[7:0] = b;
					frame_pos = POS_ADDR_HI;
				end
				POS_ADDR_HI: begin
					addr_word[15:8] = b;
					frame_pos = POS_CNT_LO;
				end
				POS_CNT_LO: begin
					count_left[7:0] = b;
					frame_pos = POS_CNT_HI;
				end
				default: begin
					count_left[15:8] = b;
					frame_pos = POS_BURST;
				end
			endcase
			r.byte_taken = 1'b1;
			return r;
		end
		a = addr_word[ADDR_W-1:0];
		if (a < range_lo || a > range_hi || count_left == '0) begin
			frame_pos = POS_SYNC1;
			return r;
		end
		if (addr_word[WORD_W-1]) begin
			if (!bv)
				return r;
			r.byte_taken = 1'b1;
			r.action = ACT_WRITE;
			r.reg_addr = a;
			r.write_data = b;
		end else begin
			r.action = ACT_READ;
			r.reg_addr = a;
		end
		addr_word = addr_word + 16'd1;
		count_left = count_left - 16'd1;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch on %s: got %0h, want %0h at %0t", field, got, want, $time);
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			hold_cycles = quiet ? 0 : int'($urandom_range(0, 18));
			if (poll_outcomes_due.size() == 0) begin
				report_mismatch("unexpected item", 32'({action, reg_addr}), 32'h0);
			end else begin
				due_outcome = poll_outcomes_due.pop_front();
				if (byte_taken !== due_outcome.byte_taken)
					report_mismatch("byte_taken", 32'(byte_taken),
						32'(due_outcome.byte_taken));
				if (action !== due_outcome.action)
					report_mismatch("action", 32'(action), 32'(due_outcome.action));
				if (reg_addr !== due_outcome.reg_addr)
					report_mismatch("reg_addr", 32'(reg_addr), 32'(due_outcome.reg_addr));
				if (write_data !== due_outcome.write_data)
					report_mismatch("write_data", 32'(write_data),
						32'(due_outcome.write_data));
			end
		end
	end

	task automatic send_poll(input logic bv, input logic [BYTE_W-1:0] b, output logic taken);
		int      gap;
		result_t r;
		gap = quiet ? 0 : int'($urandom_range(0, 18));
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		byte_valid <= bv;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = parse_poll(bv, b);
		poll_outcomes_due.push_back(r);
		taken = r.byte_taken;
	endtask

	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (poll_outcomes_due.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_addr_window(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= CFG_ADDR_LOW;
		wr_data <= lo;
		@(negedge clk);
		wr_index <= CFG_ADDR_HIGH;
		wr_data <= hi;
		@(negedge clk);
		wr_en <= 1'b0;
		range_lo = lo;
		range_hi = hi;
	endtask

	task automatic poll_sequence(input logic [8:0] polls[]);
		logic taken;
		foreach (polls[i])
			send_poll(polls[i][8], polls[i][7:0], taken);
	endtask

	task automatic test_sync_hunting();
		poll_sequence('{{1'b0, 8'hFF}, {1'b1, 8'h00}, {1'b1, SYNC_FIRST}, {1'b1, SYNC_FIRST},
			{1'b1, SYNC_SECOND}});
	endtask

	// read at the top address carries into the write bit
	task automatic test_carry_into_write_bit();
		poll_sequence('{{1'b1, SYNC_FIRST}, {1'b1, SYNC_SECOND}, {1'b1, 8'hFF}, {1'b1, 8'h7F},
			{1'b0, 8'h00}, {1'b1, 8'h03}, {1'b1, 8'h00},
			{1'b1, 8'hAB}, {1'b0, 8'hFF}, {1'b1, 8'hFF}, {1'b1, 8'h00},
			{1'b1, 8'h12}, {1'b1, 8'h12}});
	endtask

	task automatic test_empty_range();
		settle_idle();
		set_addr_window(15'd5, 15'd4);
		poll_sequence('{{1'b1, SYNC_FIRST}, {1'b1, SYNC_SECOND}, {1'b1, 8'h05}, {1'b1, 8'h80},
			{1'b1, 8'h01}, {1'b1, 8'h00}, {1'b1, 8'h77}, {1'b1, 8'h77}});
	endtask

	function automatic logic [ADDR_W-1:0] pick_addr();
		case ($urandom_range(0, 9))
			0: return range_lo;
			1: return range_hi;
			2: return range_lo - 15'd1;
			3: return range_hi + 15'd1;
			4: return 15'($urandom_range(0, 32767));
			default: begin
				if (range_lo <= range_hi)
					return 15'($urandom_range(range_lo, range_hi));
				return 15'($urandom_range(0, 32767));
			end
		endcase
	endfunction

	task automatic plan_traffic();
		int                kind;
		int                n;
		logic [ADDR_W-1:0] a;
		logic [WORD_W-1:0] word;
		logic [WORD_W-1:0] cnt;
		logic [BYTE_W-1:0] b;
		kind = int'($urandom_range(0, 19));
		if (kind < 15) begin
			a = pick_addr();
			word = {1'($urandom_range(0, 1)), a};
			// long bursts only where the window end cuts them short
			if ((a < range_lo || a > range_hi ||
					(range_hi != 15'h7FFF && range_hi - a < 15'd8)) &&
					$urandom_range(0, 2) == 0)
				cnt = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
			else
				cnt = 16'($urandom_range(0, 6));
			byte_stream.push_back(SYNC_FIRST);
			byte_stream.push_back(SYNC_SECOND);
			byte_stream.push_back(word[7:0]);
			byte_stream.push_back(word[15:8]);
			byte_stream.push_back(cnt[7:0]);
			byte_stream.push_back(cnt[15:8]);
			if (word[WORD_W-1]) begin
				n = (cnt > 16'd8) ? 8 : int'(cnt);
				repeat (n) byte_stream.push_back(8'($urandom_range(0, 255)));
			end
		end else if (kind < 17) begin
			byte_stream.push_back(SYNC_FIRST);
			if ($urandom_range(0, 1)) begin
				b = 8'($urandom_range(0, 255));
				byte_stream.push_back(b == SYNC_SECOND ? b + 8'd1 : b);
			end else begin
				byte_stream.push_back(SYNC_SECOND);
				repeat ($urandom_range(0, 3))
					byte_stream.push_back(8'($urandom_range(0, 255)));
			end
		end else begin
			repeat ($urandom_range(1, 4)) byte_stream.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_random_frames();
		logic [ADDR_W-1:0] window_lo[8];
		logic [ADDR_W-1:0] window_hi[8];
		logic              bv;
		logic              taken;
		logic [BYTE_W-1:0] b;
		window_lo = '{15'd0, 15'h7FFF, 15'd0, 15'd5, 15'd100, 15'd0, 15'h7FF0, 15'd0};
		window_hi = '{15'h7FFF, 15'h7FFF, 15'd0, 15'd4, 15'd120, 15'd0, 15'h7FFF, 15'h7FFF};
		window_lo[5] = 15'($urandom_range(0, 32767));
		window_hi[5] = 15'($urandom_range(window_lo[5], 32767));
		for (int ph = 0; ph < 8; ph++) begin
			settle_idle();
			set_addr_window(window_lo[ph], window_hi[ph]);
			for (int n = 0; n < 180; n++) begin
				if (n % 45 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				if (byte_stream.size() == 0)
					plan_traffic();
				bv = ($urandom_range(0, 7) != 0);
				b = bv ? byte_stream[0] : 8'($urandom_range(0, 255));
				send_poll(bv, b, taken);
				if (taken)
					void'(byte_stream.pop_front());
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_sync_hunting();
		test_carry_into_write_bit();
		test_empty_range();
		test_random_frames();
		settle_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/srafp_pkg.sv
sv/srafp_parser.sv
sv/serial_register_access_frame_parser.sv
tb/serial_register_access_frame_parser_test.sv
